// ----- design/slid_pkg.sv -----
// shared types and constants for the sorted list with insert and distance query
// no dependencies
package slid_pkg;

  localparam int DefDepth = 64;
  localparam int ValW     = 32;
  localparam int ActW     = 2;
  localparam int StatW    = 2;
  localparam int DistW    = 7;

  typedef enum logic [ActW-1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_cmd_t;

endpackage

// ----- design/slid_cell.sv -----
// one list cell: holds a value, compares it with the broadcast key, loads or shifts
// depends on slid_pkg
module slid_cell import slid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   occ_i,
  input  logic signed [ValW-1:0] key_i,
  input  logic signed [ValW-1:0] left_i,
  input  cell_cmd_t              cmd_i,
  output logic signed [ValW-1:0] data_o,
  output logic                   eq_o,
  output logic                   gt_o
);

  logic signed [ValW-1:0] data_q, data_d;

  assign eq_o   = occ_i && (data_q == key_i);
  assign gt_o   = occ_i && (data_q > key_i);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (cmd_i.load) begin
      data_d = key_i;
    end else if (cmd_i.shift) begin
      data_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ----- design/slid_locate.sv -----
// prefix and suffix scans over the cell flags: insert place, first and last match
// depends on slid_pkg
module slid_locate import slid_pkg::*; #(
  parameter int DEPTH = DefDepth,
  localparam int IdxW = $clog2(DEPTH)
) (
  input  logic [DEPTH-1:0] gt_i,
  input  logic [DEPTH-1:0] eq_i,
  input  logic [DEPTH-1:0] occ_i,
  input  logic [DEPTH-1:0] tail_i,
  output logic [DEPTH-1:0] ins_load_o,
  output logic [DEPTH-1:0] ins_shift_o,
  output logic             hit_o,
  output logic [IdxW-1:0]  first_idx_o,
  output logic [IdxW-1:0]  last_idx_o
);

  logic [DEPTH-1:0] pre_gt, pre_eq, suf_eq, first_gt, first_eq, last_eq;

  always_comb begin
    pre_gt = gt_i;
    pre_eq = eq_i;
    suf_eq = eq_i;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      pre_gt = pre_gt | (pre_gt << s);
      pre_eq = pre_eq | (pre_eq << s);
      suf_eq = suf_eq | (suf_eq >> s);
    end
  end

  assign first_gt = gt_i & ~(pre_gt << 1);
  assign first_eq = eq_i & ~(pre_eq << 1);
  assign last_eq  = eq_i & ~(suf_eq >> 1);
  assign hit_o    = pre_eq[DEPTH-1];

  assign ins_load_o  = first_gt | ({DEPTH{~pre_gt[DEPTH-1]}} & tail_i);
  assign ins_shift_o = (pre_gt << 1) & (occ_i | tail_i);

  always_comb begin
    first_idx_o = '0;
    last_idx_o  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      first_idx_o = first_idx_o | (first_eq[i] ? IdxW'(i) : '0);
      last_idx_o  = last_idx_o  | (last_eq[i]  ? IdxW'(i) : '0);
    end
  end

endmodule

// ----- design/sorted_list_insert_and_distance.sv -----
// sorted list of signed values in a chain of cells with append, insert and distance query
// a transaction is captured into registers, then the cell chain updates once and the result is registered
// no new transaction is taken while one is in the cell update; a result waiting at the output
// holds off the next input
// reset: entry count and handshake state clear at once; cell contents stay undefined
// depends on slid_pkg, slid_cell, slid_locate
module sorted_list_insert_and_distance import slid_pkg::*; #(
  parameter int DEPTH = DefDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ActW-1:0]        action_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [StatW-1:0]       status_o,
  output logic                   found_o,
  output logic [DistW-1:0]       distance_o
);

  localparam int IdxW     = $clog2(DEPTH);
  localparam int CntW     = $clog2(DEPTH + 1);
  localparam int DistExtW = (CntW > DistW) ? CntW : DistW;

  logic                   busy_q, busy_d;
  logic [ActW-1:0]        act_q;
  logic signed [ValW-1:0] val_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [StatW-1:0]       status_q, status_d;
  logic                   found_q, found_d;
  logic [DistW-1:0]       dist_q, dist_d;

  logic [DEPTH-1:0] occ, tail, eq, gt, ins_load, ins_shift;
  logic             hit, full, do_append, do_insert;
  logic [IdxW-1:0]  first_idx, last_idx;
  logic [CntW-1:0]  from_head, from_tail, dist_cnt;
  logic [DistExtW-1:0] dist_ext;
  cell_cmd_t        cmd [DEPTH];
  logic signed [ValW-1:0] cell_data [DEPTH];

  assign in_ready_o  = !busy_q && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign distance_o  = dist_q;

  assign full = (cnt_q == CntW'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i]  = CntW'(i) < cnt_q;
      tail[i] = CntW'(i) == cnt_q;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    slid_cell u_cell (
      .clk_i  (clk_i),
      .occ_i  (occ[g]),
      .key_i  (val_q),
      .left_i ((g == 0) ? val_q : cell_data[(g == 0) ? 0 : g - 1]),
      .cmd_i  (cmd[g]),
      .data_o (cell_data[g]),
      .eq_o   (eq[g]),
      .gt_o   (gt[g])
    );
  end

  slid_locate #(.DEPTH(DEPTH)) u_locate (
    .gt_i        (gt),
    .eq_i        (eq),
    .occ_i       (occ),
    .tail_i      (tail),
    .ins_load_o  (ins_load),
    .ins_shift_o (ins_shift),
    .hit_o       (hit),
    .first_idx_o (first_idx),
    .last_idx_o  (last_idx)
  );

  assign do_append = busy_q && (act_q == ACT_APPEND) && !full;
  assign do_insert = busy_q && (act_q == ACT_INSERT) && !full && !hit;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cmd[i].load  = (do_append && tail[i]) || (do_insert && ins_load[i]);
      cmd[i].shift = do_insert && ins_shift[i];
    end
  end

  assign from_head = hit ? (CntW'(first_idx) + CntW'(1)) : cnt_q;
  assign from_tail = hit ? (cnt_q - CntW'(last_idx)) : cnt_q;
  assign dist_cnt  = (from_head <= from_tail) ? from_head : from_tail;
  assign dist_ext  = DistExtW'(dist_cnt);

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    found_d     = found_q;
    dist_d      = dist_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      busy_d = 1'b1;
    end
    if (busy_q) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      status_d    = ST_DONE;
      found_d     = 1'b0;
      dist_d      = '0;
      if (do_append || do_insert) begin
        cnt_d = cnt_q + CntW'(1);
      end
      case (act_q)
        ACT_APPEND: begin
          if (full) begin
            status_d = ST_FULL;
          end
        end
        ACT_INSERT: begin
          if (hit) begin
            status_d = ST_DUP;
          end else if (full) begin
            status_d = ST_FULL;
          end
        end
        ACT_QUERY: begin
          found_d = hit;
          dist_d  = dist_ext[DistW-1:0];
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
    dist_q   <= dist_d;
    if (in_valid_i && in_ready_o) begin
      act_q <= action_i;
      val_q <= value_i;
    end
  end

endmodule

// ----- tb/slid_list_checker.sv -----
`timescale 1ns / 100ps
// checker for sorted_list_insert_and_distance: watches both channels, mirrors the list
// and compares every result transaction with the predicted one
// depends on slid_pkg
module slid_list_checker import slid_pkg::*; #(
  parameter int DEPTH = DefDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [ActW-1:0]        action_i,
  input  logic signed [ValW-1:0] value_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [StatW-1:0]       status_i,
  input  logic                   found_i,
  input  logic [DistW-1:0]       distance_i,
  output int                     fail_cnt_o,
  output int                     pending_cnt_o
);

  typedef struct packed {
    logic [StatW-1:0] status;
    logic             found;
    logic [DistW-1:0] distance;
  } list_result_t;

  logic signed [ValW-1:0] list_vals [DEPTH];
  int                     list_len;
  list_result_t           pending_results [$];

  initial begin
    fail_cnt_o    = 0;
    pending_cnt_o = 0;
    list_len      = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_cnt_o++;
  endtask

  task automatic apply_list_op(input logic [ActW-1:0] act, input logic signed [ValW-1:0] val,
                               output list_result_t res);
    logic dup;
    logic hit;
    int   pos;
    int   from_head;
    int   from_tail;
    res = '0;
    res.status = ST_DONE;
    case (act)
      ACT_APPEND: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_vals[list_len] = val;
          list_len++;
        end
      end
      ACT_INSERT: begin
        dup = 1'b0;
        pos = list_len;
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] == val) dup = 1'b1;
          if (pos == list_len && list_vals[i] > val) pos = i;
        end
        if (dup) begin
          res.status = ST_DUP;
        end else if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      ACT_QUERY: begin
        from_head = list_len;
        from_tail = list_len;
        hit = 1'b0;
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] == val) begin
            if (!hit) from_head = i + 1;
            from_tail = list_len - i;
            hit = 1'b1;
          end
        end
        res.found    = hit;
        res.distance = DistW'((from_head <= from_tail) ? from_head : from_tail);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    list_result_t res;
    list_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        apply_list_op(action_i, value_i, res);
        pending_results.push_back(res);
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected", status_i, -1);
        end else begin
          want = pending_results.pop_front();
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (found_i !== want.found) report_mismatch("found", found_i, want.found);
          if (distance_i !== want.distance)
            report_mismatch("distance", distance_i, want.distance);
        end
      end
      pending_cnt_o = pending_results.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// top of the testbench for sorted_list_insert_and_distance: clock, reset, stimulus and verdict
// depends on slid_pkg, the block and slid_list_checker
module tb;
  import slid_pkg::*;

  localparam int               Depth      = DefDepth;
  localparam logic [ActW-1:0]  ActUnused  = 2'd3;
  localparam int               RandItems  = 1428;
  localparam int               CalmItems  = 150;
  localparam int               HoldAt     = 700;
  localparam int               LongHold   = 300;
  localparam longint           LimitNs    = 5_000_000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [ActW-1:0]        action;
  logic signed [ValW-1:0] value;
  logic                   out_valid;
  logic                   out_ready;
  logic [StatW-1:0]       status;
  logic                   found;
  logic [DistW-1:0]       distance;
  int                     fail_cnt;
  int                     pending_cnt;

  int                     sent_cnt;
  logic                   calm;
  logic                   long_hold_done;
  logic signed [ValW-1:0] offered_vals [$];

  sorted_list_insert_and_distance #(.DEPTH(Depth)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .found_o     (found),
    .distance_o  (distance)
  );

  slid_list_checker #(.DEPTH(Depth)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .action_i      (action),
    .value_i       (value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .found_i       (found),
    .distance_i    (distance),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LimitNs);
    $display("sorted_list_insert_and_distance test failed");
    $finish;
  end

  function automatic logic signed [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 3 && offered_vals.size() > 0)
      return offered_vals[$urandom_range(0, offered_vals.size() - 1)];
    if (r <= 5) return $signed(ValW'($urandom_range(0, 40))) - 20;
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [ActW-1:0] pick_action();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 5) return ACT_QUERY;
    if (r <= 7) return ACT_INSERT;
    if (r == 8) return ACT_APPEND;
    return ActUnused;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [ActW-1:0] act, input logic signed [ValW-1:0] val);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    offered_vals.push_back(val);
    @(negedge clk);
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    out_ready      = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_hold_done && sent_cnt >= HoldAt) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    in_valid = 1'b0;
    action   = ACT_APPEND;
    value    = '0;
    rst_n    = 1'b0;
    sent_cnt = 0;
    calm     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty list, head/middle/tail placement, duplicates, extremes, disorder
    send_item(ACT_QUERY,  32'sd5);
    send_item(ACT_INSERT, 32'sd5);
    send_item(ACT_APPEND, 32'sd9);
    send_item(ACT_APPEND, 32'sd12);
    send_item(ACT_INSERT, 32'sd7);
    send_item(ACT_INSERT, 32'sd1);
    send_item(ACT_INSERT, 32'sd20);
    send_item(ACT_INSERT, 32'sd7);
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_APPEND, 32'sh7fff_ffff);
    send_item(ACT_QUERY,  32'sh8000_0000);
    send_item(ACT_QUERY,  32'sh7fff_ffff);
    send_item(ACT_QUERY,  32'sd9);
    send_item(ACT_QUERY,  32'sd8);
    send_item(ActUnused,  32'sh7fff_ffff);
    send_item(ACT_APPEND, 32'sd9);
    send_item(ACT_QUERY,  32'sd9);
    send_item(ACT_INSERT, 32'sd9);
    send_item(ACT_APPEND, -32'sd1);
    send_item(ACT_INSERT, 32'sd10);
    send_item(ACT_QUERY,  -32'sd1);
    send_item(ActUnused,  32'sd0);

    // random mix: the list fills up, then full-table and duplicate cases dominate among inserts and appends
    for (int n = 0; n < RandItems; n++) begin
      if (n == RandItems - CalmItems) calm = 1'b1;
      send_item(pick_action(), pick_value());
    end
    in_valid <= 1'b0;

    while (pending_cnt != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("sorted_list_insert_and_distance test passed");
    end else begin
      $display("sorted_list_insert_and_distance test failed");
    end
    $finish;
  end

endmodule

// ----- sorted_list_insert_and_distance.f -----
design/slid_pkg.sv
design/slid_cell.sv
design/slid_locate.sv
design/sorted_list_insert_and_distance.sv
tb/slid_list_checker.sv
tb/tb.sv
